>>> rtl/tpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int BUNDLE_MAX = 6;
    localparam int CNT_W      = $clog2(BUNDLE_MAX + 1);
    localparam int IN_DATA_W  = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd255;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_OUTSIDE  = 2'd2
    } t_err;

    typedef enum logic [0:0] {
        REG_START_BYTE  = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [BUNDLE_MAX-1:0][BYTE_W-1:0] data;
        logic [CNT_W-1:0]                  count;
        logic                              eop;
        t_err                              err;
    } t_bundle;

endpackage

`default_nettype wire

>>> rtl/telemetry_packet_framer_core.sv
// Telemetry packet framer.
// Input stream (s_axis): one request per handshake. tuser[0] set opens a new
// packet and carries its type and length; otherwise the request carries one
// payload byte. Output stream (m_axis): one framed byte per handshake, tlast on
// the closing checksum byte or on an error byte, tuser carries the error code.
// An opening request emits start byte, type, length low, length high, then its
// payload byte (five results; six for a one-byte packet; five for an empty
// packet ending in checksum 0). Later requests emit their byte, plus the XOR
// checksum after the last one. Oversize requests and stray bytes give a
// single zero byte with tlast and an error code.
// The first output byte appears in the cycle after its request is taken.
// A one-byte request can be taken every cycle while the output is ready; a
// longer one holds the input until the single output byte register drains.
// The input is ready whenever the output register is empty or delivers its
// last byte in the same cycle, so an output stall holds the input back.
// Reset clears the open packet and pending output and restores the start
// byte to 0xAA and the maximum payload to 255; the APB port sets both.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_packet_framer_core
    import tpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] packet_type, [23:8] payload_length, [31:24] data_byte
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] opens_packet
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] out_byte
    output logic      [BYTE_W-1:0]     m_axis_tdata,
    output logic                       m_axis_tlast,
    // [1:0] error_code
    output logic      [1:0]            m_axis_tuser,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [BYTE_W-1:0] start_byte;
    logic [LEN_W-1:0]  max_payload;
    logic              accept;
    logic              can_load;
    t_bundle           bundle;
    t_err              out_err;

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;
    assign m_axis_tuser  = out_err;

    tpf_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_start_byte  (start_byte),
        .o_max_payload (max_payload)
    );

    tpf_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_opens_packet   (s_axis_tuser[0]),
        .i_packet_type    (s_axis_tdata[7:0]),
        .i_payload_length (s_axis_tdata[23:8]),
        .i_data_byte      (s_axis_tdata[31:24]),
        .i_start_byte     (start_byte),
        .i_max_payload    (max_payload),
        .o_bundle         (bundle)
    );

    tpf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_bundle    (bundle),
        .i_out_ready (m_axis_tready),
        .o_can_load  (can_load),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_eop   (m_axis_tlast),
        .o_out_err   (out_err)
    );

endmodule

`default_nettype wire

>>> rtl/tpf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module tpf_cfg
    import tpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [BYTE_W-1:0]     o_start_byte,
    output logic      [LEN_W-1:0]      o_max_payload
);

    logic [BYTE_W-1:0] r_start_byte;
    logic [LEN_W-1:0]  r_max_payload;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_BYTE_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_BYTE:  r_start_byte  <= pwdata[BYTE_W-1:0];
                REG_MAX_PAYLOAD: r_max_payload <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE:  prdata = APB_DATA_W'(r_start_byte);
            REG_MAX_PAYLOAD: prdata = APB_DATA_W'(r_max_payload);
            default:         prdata = '0;
        endcase
    end

    assign o_start_byte  = r_start_byte;
    assign o_max_payload = r_max_payload;

endmodule

`default_nettype wire

>>> rtl/tpf_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module tpf_engine
    import tpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_opens_packet,
    input  wire logic [BYTE_W-1:0] i_packet_type,
    input  wire logic [LEN_W-1:0]  i_payload_length,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [BYTE_W-1:0] i_start_byte,
    input  wire logic [LEN_W-1:0]  i_max_payload,
    output t_bundle                o_bundle
);

    logic              r_in_packet;
    logic [LEN_W-1:0]  r_remaining;
    logic [BYTE_W-1:0] r_xor;
    logic              n_in_packet;
    logic [LEN_W-1:0]  n_remaining;
    logic [BYTE_W-1:0] n_xor;

    always_comb begin
        n_in_packet    = r_in_packet;
        n_remaining    = r_remaining;
        n_xor          = r_xor;
        o_bundle.data  = '0;
        o_bundle.count = CNT_W'(1);
        o_bundle.eop   = 1'b0;
        o_bundle.err   = ERR_NONE;
        if (i_opens_packet) begin
            // A new request always abandons whatever packet was open.
            n_in_packet = 1'b0;
            n_remaining = '0;
            n_xor       = '0;
            if (i_payload_length > i_max_payload) begin
                o_bundle.eop = 1'b1;
                o_bundle.err = ERR_TOO_LONG;
            end else begin
                o_bundle.data[0] = i_start_byte;
                o_bundle.data[1] = i_packet_type;
                o_bundle.data[2] = i_payload_length[BYTE_W-1:0];
                o_bundle.data[3] = i_payload_length[LEN_W-1:BYTE_W];
                o_bundle.count   = CNT_W'(5);
                if (i_payload_length == '0) begin
                    o_bundle.eop = 1'b1;
                end else begin
                    o_bundle.data[4] = i_data_byte;
                    if (i_payload_length == LEN_W'(1)) begin
                        o_bundle.data[5] = i_data_byte;
                        o_bundle.count   = CNT_W'(6);
                        o_bundle.eop     = 1'b1;
                    end else begin
                        n_in_packet = 1'b1;
                        n_remaining = i_payload_length - LEN_W'(1);
                        n_xor       = i_data_byte;
                    end
                end
            end
        end else if (!r_in_packet) begin
            o_bundle.eop = 1'b1;
            o_bundle.err = ERR_OUTSIDE;
        end else begin
            o_bundle.data[0] = i_data_byte;
            if (r_remaining == LEN_W'(1)) begin
                o_bundle.data[1] = r_xor ^ i_data_byte;
                o_bundle.count   = CNT_W'(2);
                o_bundle.eop     = 1'b1;
                n_in_packet      = 1'b0;
                n_remaining      = '0;
                n_xor            = '0;
            end else begin
                n_remaining = r_remaining - LEN_W'(1);
                n_xor       = r_xor ^ i_data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_remaining <= '0;
            r_xor       <= '0;
        end else if (i_accept) begin
            r_in_packet <= n_in_packet;
            r_remaining <= n_remaining;
            r_xor       <= n_xor;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tpf_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

module tpf_serializer
    import tpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire t_bundle           i_bundle,
    input  wire logic              i_out_ready,
    output logic                   o_can_load,
    output logic                   o_out_valid,
    output logic      [BYTE_W-1:0] o_out_byte,
    output logic                   o_out_eop,
    output t_err                   o_out_err
);

    logic                              r_valid;
    logic [CNT_W-1:0]                  r_idx;
    logic [CNT_W-1:0]                  r_cnt;
    logic [BUNDLE_MAX-1:0][BYTE_W-1:0] r_data;
    logic                              r_eop;
    t_err                              r_err;
    logic                              last;

    assign last        = (r_idx == r_cnt - CNT_W'(1));
    assign o_can_load  = !r_valid || (i_out_ready && last);
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_data[r_idx];
    assign o_out_eop   = r_eop && last;
    assign o_out_err   = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
            r_cnt   <= i_bundle.count;
        end else if (r_valid && i_out_ready) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_bundle.data;
            r_eop  <= i_bundle.eop;
            r_err  <= i_bundle.err;
        end
    end

    a_load_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("accepted request produced no pending output");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_cnt))
        else $error("output index ran past the bundle");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("bundle overwritten before it was drained");

    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err != ERR_NONE) |-> (o_out_eop && r_cnt == CNT_W'(1)))
        else $error("error result is not a single closing byte");

endmodule

`default_nettype wire
